[sv/gif_lzw_decoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// GIF LZW decoder assertion macros
// Clocked property helpers used by the decoder engine RTL (glzw_back).
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_UNIT_ASSERT_SVH
`define GIF_LZW_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GLZW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glzw assertion failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GLZW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glzw assertion failed");
`else
`define GLZW_ASSERT_IMP(lbl, ante, cons)
`define GLZW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/glzw_pkg.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Item, dictionary entry and status types shared by the decoder modules.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int CODE_W = 12;
  localparam int NFC_W  = 13;
  localparam int LEN_W  = 13;
  localparam int PW_W   = 17;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DECODING = 2'd0,
    ST_END      = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    op_e         kind;
    logic [7:0]  data_byte;
    logic [15:0] pixel_index;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
  } dict_entry_t;

  localparam int DICT_W = $bits(dict_entry_t);

endpackage

[sv/glzw_ram.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder RAM
// Simple dual-port memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/glzw_front.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder front end
// Accepts items, classifies the operation and queues them for the engine.
// ----------------------------------------------------------------------------
module glzw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          data_byte_i,
  input  logic [15:0]         pixel_index_i,
  output logic                item_valid_o,
  output glzw_pkg::item_t     item_o,
  input  logic                item_pop_i
);
  import glzw_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;
  item_t       incoming;

  always_comb begin
    incoming.kind        = op_e'(operation_i);
    incoming.data_byte   = data_byte_i;
    incoming.pixel_index = pixel_index_i;
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

[sv/glzw_back.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder engine
// Unpacks codes, walks the dictionary, writes pixels to the image store and serves pixel reads.
// ----------------------------------------------------------------------------
`include "gif_lzw_decoder_unit_assert.svh"

module glzw_back #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_PIXELS    = 65536,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  glzw_pkg::item_t item_i,
  output logic            item_pop_o,
  input  logic [3:0]      min_code_size_i,
  input  logic [16:0]     image_pixels_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      pixel_value_o,
  output logic [1:0]      decode_status_o,
  output logic [16:0]     pixels_written_o
);
  import glzw_pkg::*;

  localparam int DICT_AW = $clog2(DICT_ENTRIES);
  localparam int IMG_AW  = $clog2(MAX_PIXELS);
  localparam logic [20:0] MaxPix = 21'(MAX_PIXELS);
  localparam logic [NFC_W-1:0] DictEnd = NFC_W'(DICT_ENTRIES);
  localparam logic [3:0] MaxBits = 4'(MAX_CODE_BITS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UNPACK = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_ROOT   = 7'b0001000,
    S_FINISH = 7'b0010000,
    S_READ   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        root_q, root_d;
  logic [19:0]       acc_q, acc_d;
  logic [4:0]        held_q, held_d;
  logic [3:0]        width_q, width_d;
  logic [NFC_W-1:0]  nfc_q, nfc_d;
  logic [CODE_W-1:0] prev_q, prev_d;
  logic [LEN_W-1:0]  prev_len_q, prev_len_d;
  logic              pv_q, pv_d;
  logic [7:0]        sub_q, sub_d;
  logic [16:0]       wp_q, wp_d;
  status_e           status_q, status_d;
  logic [7:0]        pix_q, pix_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              kwk_q, kwk_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [17:0]       pos_q, pos_d;
  logic [7:0]        first_q, first_d;
  logic              first_step_q, first_step_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_pix_q;
  logic [1:0]        out_status_q;
  logic [16:0]       out_pw_q;
  logic              out_load;

  logic              dict_we;
  logic [DICT_AW-1:0] dict_waddr, dict_raddr;
  dict_entry_t       dict_wdata, dict_rdata;
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr, img_raddr;
  logic [7:0]        img_wdata, img_rdata;

  logic [NFC_W-1:0]  clear_code;
  logic [16:0]       limit;
  logic [19:0]       code_mask;
  logic [CODE_W-1:0] code;
  logic [NFC_W-1:0]  code13;
  logic [CODE_W-1:0] wcode;
  logic              kwk;
  logic [17:0]       pos;
  logic [17:0]       end_pos;
  logic [17:0]       kwk_pos;
  logic [LEN_W:0]    total;
  logic [3:0]        new_root;
  logic [NFC_W-1:0]  nfc_inc;
  logic [NFC_W-1:0]  new_clear;

  glzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (dict_wdata),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(MAX_PIXELS)) u_image (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  assign clear_code = NFC_W'(1) << root_q;
  assign limit      = ({4'd0, image_pixels_i} < MaxPix) ? image_pixels_i : MaxPix[16:0];
  assign code_mask  = (20'd1 << width_q) - 20'd1;
  assign code       = CODE_W'(acc_q & code_mask);
  assign code13     = {1'b0, code};
  assign kwk        = (code13 == nfc_q);
  assign wcode      = kwk ? prev_q : code;
  assign total      = {1'b0, len_q} + (LEN_W+1)'(kwk_q);
  assign end_pos    = {1'b0, wp_q} + 18'(total);
  assign kwk_pos    = {1'b0, wp_q} + 18'(len_q);
  assign nfc_inc    = nfc_q + NFC_W'(1);
  assign new_root   = (min_code_size_i < 4'd2) ? 4'd2 :
                      (min_code_size_i > 4'd8) ? 4'd8 : min_code_size_i;
  assign new_clear  = NFC_W'(1) << new_root;
  assign pos        = first_step_q ? ({1'b0, wp_q} + 18'(dict_rdata.len) - 18'd1) : pos_q;

  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    acc_d        = acc_q;
    held_d       = held_q;
    width_d      = width_q;
    nfc_d        = nfc_q;
    prev_d       = prev_q;
    prev_len_d   = prev_len_q;
    pv_d         = pv_q;
    sub_d        = sub_q;
    wp_d         = wp_q;
    status_d     = status_q;
    pix_d        = pix_q;
    rd_ok_d      = rd_ok_q;
    code_d       = code_q;
    kwk_d        = kwk_q;
    len_d        = len_q;
    pos_d        = pos_q;
    first_d      = first_q;
    first_step_d = first_step_q;
    item_pop_o   = 1'b0;
    out_load     = 1'b0;
    dict_we      = 1'b0;
    dict_waddr   = DICT_AW'(nfc_q);
    dict_wdata   = '{len: prev_len_q + LEN_W'(1), prefix: prev_q, suffix: first_q};
    dict_raddr   = '0;
    img_we       = 1'b0;
    img_waddr    = '0;
    img_wdata    = first_q;
    img_raddr    = IMG_AW'(item_i.pixel_index);

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          pix_d      = 8'd0;
          state_d    = S_EMIT;
          unique case (item_i.kind)
            OP_PUSH: begin
              if (status_q == ST_DECODING) begin
                if (sub_q == 8'd0) begin
                  sub_d = item_i.data_byte;
                end else begin
                  sub_d   = sub_q - 8'd1;
                  acc_d   = acc_q | (20'(item_i.data_byte) << held_q);
                  held_d  = held_q + 5'd8;
                  state_d = S_UNPACK;
                end
              end
            end
            OP_READ: begin
              rd_ok_d = ({5'd0, item_i.pixel_index} < MaxPix);
              state_d = S_READ;
            end
            OP_START: begin
              root_d   = new_root;
              acc_d    = '0;
              held_d   = '0;
              width_d  = new_root + 4'd1;
              nfc_d    = new_clear + NFC_W'(2);
              prev_d   = '0;
              pv_d     = 1'b0;
              sub_d    = '0;
              wp_d     = '0;
              status_d = ST_DECODING;
            end
            default: begin
            end
          endcase
        end
      end

      S_UNPACK: begin
        if (status_q != ST_DECODING || held_q < {1'b0, width_q}) begin
          state_d = S_EMIT;
        end else begin
          acc_d  = acc_q >> width_q;
          held_d = held_q - {1'b0, width_q};
          priority if (code13 == clear_code) begin
            width_d = root_q + 4'd1;
            nfc_d   = clear_code + NFC_W'(2);
            pv_d    = 1'b0;
          end else if (code13 == clear_code + NFC_W'(1)) begin
            status_d = ST_END;
          end else if (code13 > nfc_q) begin
            status_d = ST_INVALID;
          end else if (kwk && (!pv_q || nfc_q >= DictEnd)) begin
            status_d = ST_INVALID;
          end else if (!kwk && !pv_q && code13 >= clear_code) begin
            status_d = ST_INVALID;
          end else begin
            code_d = code;
            kwk_d  = kwk;
            // A root code is its own one-pixel string; longer ones walk the chain.
            if ({1'b0, wcode} < clear_code) begin
              len_d   = LEN_W'(1);
              first_d = wcode[7:0];
              pos_d   = {1'b0, wp_q};
              state_d = S_ROOT;
            end else begin
              dict_raddr   = DICT_AW'(wcode);
              first_step_d = 1'b1;
              state_d      = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        // The chain is walked last pixel first, so pixels are placed backward.
        if (first_step_q) begin
          len_d = dict_rdata.len;
        end
        first_step_d = 1'b0;
        img_we       = (pos < {1'b0, limit});
        img_waddr    = IMG_AW'(pos);
        img_wdata    = dict_rdata.suffix;
        pos_d        = pos - 18'd1;
        if ({1'b0, dict_rdata.prefix} >= clear_code + NFC_W'(2)) begin
          dict_raddr = DICT_AW'(dict_rdata.prefix);
        end else begin
          first_d = dict_rdata.prefix[7:0];
          state_d = S_ROOT;
        end
      end

      S_ROOT: begin
        img_we    = (pos_q < {1'b0, limit});
        img_waddr = IMG_AW'(pos_q);
        state_d   = S_FINISH;
      end

      S_FINISH: begin
        img_we    = kwk_q && (kwk_pos < {1'b0, limit});
        img_waddr = IMG_AW'(kwk_pos);
        state_d   = S_UNPACK;
        if (end_pos > {1'b0, limit}) begin
          // A count already past a lowered limit stays where it is.
          if (wp_q < limit) begin
            wp_d = limit;
          end
          status_d = ST_OVERFLOW;
        end else begin
          wp_d = end_pos[16:0];
          if (pv_q && nfc_q < DictEnd) begin
            dict_we = 1'b1;
            nfc_d   = nfc_inc;
            if (nfc_inc == (NFC_W'(1) << width_q) && width_q < MaxBits) begin
              width_d = width_q + 4'd1;
            end
          end
          prev_d     = code_q;
          prev_len_d = LEN_W'(total);
          pv_d       = 1'b1;
        end
      end

      S_READ: begin
        pix_d   = rd_ok_q ? img_rdata : 8'd0;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= 4'd8;
      acc_q       <= '0;
      held_q      <= '0;
      width_q     <= 4'd9;
      nfc_q       <= NFC_W'(258);
      prev_q      <= '0;
      pv_q        <= 1'b0;
      sub_q       <= '0;
      wp_q        <= '0;
      status_q    <= ST_DECODING;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      width_q     <= width_d;
      nfc_q       <= nfc_d;
      prev_q      <= prev_d;
      pv_q        <= pv_d;
      sub_q       <= sub_d;
      wp_q        <= wp_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_len_q   <= prev_len_d;
    pix_q        <= pix_d;
    rd_ok_q      <= rd_ok_d;
    code_q       <= code_d;
    kwk_q        <= kwk_d;
    len_q        <= len_d;
    pos_q        <= pos_d;
    first_q      <= first_d;
    first_step_q <= first_step_d;
    if (out_load) begin
      out_pix_q    <= pix_q;
      out_status_q <= status_q;
      out_pw_q     <= wp_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_value_o    = out_pix_q;
  assign decode_status_o  = out_status_q;
  assign pixels_written_o = out_pw_q;

  `GLZW_ASSERT_NXT(a_status_sticky, (status_q != ST_DECODING) && !(state_q == S_IDLE && item_valid_i && item_i.kind == OP_START), status_q != ST_DECODING)
  `GLZW_ASSERT_IMP(a_dict_write_room, dict_we, nfc_q < DictEnd)
  `GLZW_ASSERT_IMP(a_pop_when_idle, item_pop_o, state_q == S_IDLE)
  `GLZW_ASSERT_IMP(a_emit_slot_free, out_load, !out_valid_q || !out_stall_i)

endmodule

[sv/gif_lzw_decoder_unit.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder unit
// Decodes a raw GIF image-data byte stream into a readable pixel store.
// ----------------------------------------------------------------------------
// Each item is a stream byte push, a pixel read, a new-image start or a no-op,
// and each gives one result with the pixel read, the decode status and the
// pixel count. A data byte also decodes every code that it completes, and for
// each such code the engine walks the prefix chain one entry a cycle through
// the single read port of the dictionary RAM. A two-item queue in front lets
// the source keep sending while the engine works. No memory needs a clearing
// pass.
module gif_lzw_decoder_unit #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_PIXELS    = 65536,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] pixel_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_value_o,
  output logic [1:0]  decode_status_o,
  output logic [16:0] pixels_written_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import glzw_pkg::*;

  localparam logic CfgMinCode = 1'b0;
  localparam logic CfgPixels  = 1'b1;

  logic [3:0]  min_code_size_q;
  logic [16:0] image_pixels_q;
  logic        item_valid;
  logic        item_pop;
  item_t       item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_code_size_q <= 4'd8;
      image_pixels_q  <= 17'h10000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMinCode: min_code_size_q <= cfg_data_i[3:0];
        CfgPixels:  image_pixels_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  glzw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .pixel_index_i (pixel_index_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  glzw_back #(
    .DICT_ENTRIES  (DICT_ENTRIES),
    .MAX_PIXELS    (MAX_PIXELS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_pop_o       (item_pop),
    .min_code_size_i  (min_code_size_q),
    .image_pixels_i   (image_pixels_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_value_o    (pixel_value_o),
    .decode_status_o  (decode_status_o),
    .pixels_written_o (pixels_written_o)
  );

endmodule
